// File: rtl/ebb_pkg.sv
// Shared constants, codes and width helpers for the edge-normalized box blur.
`default_nettype none

package ebb_pkg;

  localparam int PIX_W            = 8;
  localparam int PIX_MAX          = 255;
  localparam int FRAME_WIDTH_W    = 11;
  localparam int FRAME_HEIGHT_W   = 12;
  localparam int ROW_W            = 12;
  localparam int CFG_DATA_W       = 12;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;
  localparam int QUEUE_DEPTH      = 4;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Rows held in the line store ring.
  function automatic int ring_rows(int radius);
    return 3 * radius + 1;
  endfunction

  function automatic int ring_w(int radius);
    return $clog2(3 * radius + 1);
  endfunction

  function automatic int col_w(int max_width);
    return $clog2(max_width);
  endfunction

  // Holds a window span of 1 .. 2*radius+1.
  function automatic int span_w(int radius);
    return $clog2(2 * radius + 2);
  endfunction

  function automatic int addr_w(int max_width, int radius);
    return $clog2((3 * radius + 1) * max_width);
  endfunction

  function automatic int cmd_w(int max_width, int radius);
    return 3 + PIX_W + addr_w(max_width, radius) + ring_w(radius) + 2 * span_w(radius)
           + col_w(max_width);
  endfunction

endpackage

`default_nettype wire

// File: rtl/ebb_intf.sv
// Channel interfaces for pixel input, blurred output and register writes.
`default_nettype none

interface pix_if;
  logic          valid;
  logic          ready;
  ebb_pkg::func_e func;
  logic [ebb_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output func, output pixel_value, input ready);
  modport sink   (input valid, input func, input pixel_value, output ready);
endinterface

interface res_if;
  logic valid;
  logic ready;
  logic [ebb_pkg::PIX_W-1:0] blurred_value;
  logic frame_last;

  modport source (output valid, output blurred_value, output frame_last, input ready);
  modport sink   (input valid, input blurred_value, input frame_last, output ready);
endinterface

interface cfg_if;
  logic                 valid;
  logic                 ready;
  ebb_pkg::cfg_reg_e    index;
  logic [ebb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/ebb_front.sv
// Front end: frame registers, raster counters and command generation per item.
`default_nettype none

module ebb_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 2,
  localparam int CMD_W    = ebb_pkg::cmd_w(MAX_WIDTH, RADIUS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cfg_if.sink              cfg_i,
  pix_if.sink              pix_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output logic [CMD_W-1:0] cmd_o
);
  import ebb_pkg::*;

  localparam int RING      = ring_rows(RADIUS);
  localparam int RING_W    = ring_w(RADIUS);
  localparam int RING_W1   = RING_W + 1;
  localparam int COL_W     = col_w(MAX_WIDTH);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int SPAN_W    = span_w(RADIUS);
  localparam int ADDR_W    = addr_w(MAX_WIDTH, RADIUS);
  localparam int DLY_W     = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
  localparam int RST_WIDTH = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic              emit;
    logic              last;
    logic [RING_W-1:0] ring0;
    logic [SPAN_W-1:0] rows;
    logic [COL_W-1:0]  col0;
    logic [SPAN_W-1:0] cols;
  } cmd_t;

  logic [WID_W-1:0]  width_q;
  logic [ROW_W-1:0]  height_q;
  logic [DLY_W-1:0]  delay_q;
  logic [DLY_W-1:0]  lin_q;
  logic [COL_W-1:0]  in_col_q;
  logic [ROW_W-1:0]  in_row_q;
  logic [RING_W-1:0] in_ring_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [RING_W-1:0] out_ring_q;

  logic cfg_wr, pix_acc, in_done, out_left, do_write, do_emit, do_restart, is_last;
  logic in_col_end, out_col_end;
  logic [SPAN_W-1:0] up_rows, down_rows, left_cols, right_cols;
  logic [ROW_W-1:0]  rows_below;
  logic [COL_W-1:0]  cols_right;
  logic [RING_W-1:0] ring0;
  logic [WID_W-1:0]  new_width;
  logic [ROW_W-1:0]  new_height;
  logic [DLY_W-1:0]  new_delay;
  logic [FRAME_WIDTH_W-1:0] cfg_width;
  cmd_t cmd;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign pix_i.ready = cmd_ready_i;
  assign pix_acc     = pix_i.valid && pix_i.ready;

  assign in_done    = in_row_q >= height_q;
  assign out_left   = out_row_q < height_q;
  assign do_write   = !in_done && (pix_i.func == FUNC_PIXEL);
  assign do_emit    = in_done ? out_left : (do_write && (lin_q == delay_q));
  assign do_restart = in_done && !out_left;
  assign is_last    = (out_row_q == height_q - ROW_W'(1)) &&
                      (WID_W'(out_col_q) == width_q - WID_W'(1));

  assign in_col_end  = (WID_W'(in_col_q) + WID_W'(1)) >= width_q;
  assign out_col_end = (WID_W'(out_col_q) + WID_W'(1)) >= width_q;

  // Clip the window at the frame borders.
  assign rows_below = height_q - ROW_W'(1) - out_row_q;
  assign cols_right = COL_W'(width_q - WID_W'(1) - WID_W'(out_col_q));
  assign up_rows    = (out_row_q >= ROW_W'(RADIUS)) ? SPAN_W'(RADIUS) : SPAN_W'(out_row_q);
  assign down_rows  = (rows_below >= ROW_W'(RADIUS)) ? SPAN_W'(RADIUS) : SPAN_W'(rows_below);
  assign left_cols  = (out_col_q >= COL_W'(RADIUS)) ? SPAN_W'(RADIUS) : SPAN_W'(out_col_q);
  assign right_cols = (cols_right >= COL_W'(RADIUS)) ? SPAN_W'(RADIUS) : SPAN_W'(cols_right);

  always_comb begin
    if (out_ring_q >= RING_W'(up_rows)) begin
      ring0 = out_ring_q - RING_W'(up_rows);
    end else begin
      ring0 = RING_W'(RING_W1'(out_ring_q) + RING_W1'(RING) - RING_W1'(up_rows));
    end
  end

  always_comb begin
    cmd.wr_en   = do_write;
    cmd.wr_addr = ADDR_W'(in_ring_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_q);
    cmd.wr_data = pix_i.pixel_value;
    cmd.emit    = do_emit;
    cmd.last    = is_last;
    cmd.ring0   = ring0;
    cmd.rows    = up_rows + down_rows + SPAN_W'(1);
    cmd.col0    = out_col_q - COL_W'(left_cols);
    cmd.cols    = left_cols + right_cols + SPAN_W'(1);
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = pix_acc && (do_write || do_emit);

  // Register writes: zero acts as one, too wide acts as the store width.
  assign cfg_width = cfg_i.data[FRAME_WIDTH_W-1:0];

  always_comb begin
    if (cfg_width == '0) begin
      new_width = WID_W'(1);
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      new_width = WID_W'(MAX_WIDTH);
    end else begin
      new_width = WID_W'(cfg_width);
    end
    new_height = (cfg_i.data[FRAME_HEIGHT_W-1:0] == '0) ? ROW_W'(1)
                                                         : cfg_i.data[FRAME_HEIGHT_W-1:0];
    new_delay  = DLY_W'(RADIUS * int'(new_width) + RADIUS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WID_W'(RST_WIDTH);
      height_q   <= ROW_W'(FRAME_HEIGHT_RST);
      delay_q    <= DLY_W'(RADIUS * RST_WIDTH + RADIUS);
      lin_q      <= '0;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
    end else if (cfg_wr) begin
      if (cfg_i.index == REG_FRAME_WIDTH) begin
        width_q <= new_width;
        delay_q <= new_delay;
      end else begin
        height_q <= new_height;
      end
      lin_q      <= '0;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
    end else if (pix_acc) begin
      // Start the next frame after its last output.
      if ((do_emit && is_last) || do_restart) begin
        lin_q      <= '0;
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_ring_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_ring_q <= '0;
      end else begin
        if (do_write) begin
          if (lin_q != delay_q) begin
            lin_q <= lin_q + DLY_W'(1);
          end
          if (in_col_end) begin
            in_col_q  <= '0;
            in_row_q  <= in_row_q + ROW_W'(1);
            in_ring_q <= (in_ring_q == RING_W'(RING - 1)) ? '0 : in_ring_q + RING_W'(1);
          end else begin
            in_col_q <= in_col_q + COL_W'(1);
          end
        end
        if (do_emit) begin
          if (out_col_end) begin
            out_col_q  <= '0;
            out_row_q  <= out_row_q + ROW_W'(1);
            out_ring_q <= (out_ring_q == RING_W'(RING - 1)) ? '0 : out_ring_q + RING_W'(1);
          end else begin
            out_col_q <= out_col_q + COL_W'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ebb_cmd_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none

module ebb_cmd_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              ready_o,
  input  logic [DATA_W-1:0] data_i,
  output logic              valid_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o
);
  import ebb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign ready_o = count_q != CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ebb_back.sv
// Back end: line store, window accumulation and reciprocal divide.
`default_nettype none

module ebb_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 2,
  localparam int CMD_W    = ebb_pkg::cmd_w(MAX_WIDTH, RADIUS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  logic [CMD_W-1:0] cmd_i,
  res_if.source            res_o
);
  import ebb_pkg::*;

  localparam int RING        = ring_rows(RADIUS);
  localparam int RING_W      = ring_w(RADIUS);
  localparam int COL_W       = col_w(MAX_WIDTH);
  localparam int SPAN_W      = span_w(RADIUS);
  localparam int ADDR_W      = addr_w(MAX_WIDTH, RADIUS);
  localparam int DEPTH       = RING * MAX_WIDTH;
  localparam int WIN_N       = (2 * RADIUS + 1) * (2 * RADIUS + 1);
  localparam int SUM_W       = $clog2(WIN_N * PIX_MAX + 1);
  localparam int CNT_W       = $clog2(WIN_N + 1);
  localparam int RECIP_SHIFT = $clog2(WIN_N * WIN_N * PIX_MAX + 1);
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic              emit;
    logic              last;
    logic [RING_W-1:0] ring0;
    logic [SPAN_W-1:0] rows;
    logic [COL_W-1:0]  col0;
    logic [SPAN_W-1:0] cols;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_MUL,
    S_DONE
  } state_e;

  // Ceiling reciprocals: floor(sum * recip >> RECIP_SHIFT) equals sum / count.
  logic [RECIP_W-1:0] recip_tbl [2**CNT_W];

  for (genvar d = 0; d < 2**CNT_W; d++) begin : g_recip
    localparam int DIV   = (d == 0) ? 1 : d;
    localparam int RECIP = (d == 0) ? 0 : ((2**RECIP_SHIFT) + DIV - 1) / DIV;
    assign recip_tbl[d] = RECIP_W'(RECIP);
  end

  logic [PIX_W-1:0]  store_mem [DEPTH];
  logic [PIX_W-1:0]  rd_data_q;

  state_e            state_q;
  logic [RING_W-1:0] ring_q;
  logic [COL_W-1:0]  x_q, c0_q;
  logic [SPAN_W-1:0] xi_q, yi_q, rows_q, cols_q;
  logic              last_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sum_q;
  logic              rd_valid_q;
  logic [PROD_W-1:0] prod_q;
  logic              out_valid_q;
  logic [PIX_W-1:0]  out_value_q;
  logic              out_last_q;

  cmd_t              cmd;
  logic              pop, mem_we, mem_re, row_end, win_end, out_free;
  logic [ADDR_W-1:0] rd_addr;
  logic [QUOT_W-1:0] quot;

  assign cmd         = cmd_i;
  assign cmd_ready_o = state_q == S_IDLE;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign mem_we      = pop && cmd.wr_en;
  assign mem_re      = state_q == S_READ;
  assign rd_addr     = ADDR_W'(ring_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_q);
  assign row_end     = xi_q == cols_q - SPAN_W'(1);
  assign win_end     = row_end && (yi_q == rows_q - SPAN_W'(1));
  assign out_free    = !out_valid_q || res_o.ready;
  assign quot        = prod_q[PROD_W-1:RECIP_SHIFT];

  assign res_o.valid         = out_valid_q;
  assign res_o.blurred_value = out_value_q;
  assign res_o.frame_last    = out_last_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (mem_re) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ring_q      <= '0;
      x_q         <= '0;
      c0_q        <= '0;
      xi_q        <= '0;
      yi_q        <= '0;
      rows_q      <= '0;
      cols_q      <= '0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      sum_q       <= '0;
      rd_valid_q  <= 1'b0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      rd_valid_q <= mem_re;
      if (rd_valid_q) begin
        sum_q <= sum_q + SUM_W'(rd_data_q);
      end
      // Drop the result after its transfer unless the next one loads now.
      if (out_valid_q && res_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (pop && cmd.emit) begin
            ring_q  <= cmd.ring0;
            x_q     <= cmd.col0;
            c0_q    <= cmd.col0;
            xi_q    <= '0;
            yi_q    <= '0;
            rows_q  <= cmd.rows;
            cols_q  <= cmd.cols;
            last_q  <= cmd.last;
            cnt_q   <= '0;
            sum_q   <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          // Walk the window row by row, one store read per cycle.
          cnt_q <= cnt_q + CNT_W'(1);
          if (row_end) begin
            xi_q   <= '0;
            x_q    <= c0_q;
            yi_q   <= yi_q + SPAN_W'(1);
            ring_q <= (ring_q == RING_W'(RING - 1)) ? '0 : ring_q + RING_W'(1);
          end else begin
            xi_q <= xi_q + SPAN_W'(1);
            x_q  <= x_q + COL_W'(1);
          end
          if (win_end) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= PROD_W'(sum_q) * PROD_W'(recip_tbl[cnt_q]);
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= (quot > QUOT_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : PIX_W'(quot);
            out_last_q  <= last_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/edge_normalized_box_blur.sv
// Edge-normalized box blur: front end, command queue and back end.
// Throughput: one item per cycle at the input while the queue has room; the back end
//   takes a command only when idle; a pixel without a result only writes the store, and a
//   result reads its clipped window (25 pixels inside the frame, 9 in a corner) one pixel
//   at a time through the single read port, then scales the sum by a reciprocal.
// Reset: counters cleared, width 640 (capped at MAX_WIDTH), height 480; store not cleared.
`default_nettype none

module edge_normalized_box_blur #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cfg_if.sink   cfg_i,
  pix_if.sink   pix_i,
  res_if.source res_o
);
  import ebb_pkg::*;

  localparam int CMD_W = cmd_w(MAX_WIDTH, RADIUS);

  logic             front_valid, front_ready;
  logic [CMD_W-1:0] front_cmd;
  logic             queue_valid, queue_ready;
  logic [CMD_W-1:0] queue_cmd;

  ebb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .RADIUS    (RADIUS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pix_i       (pix_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  ebb_cmd_fifo #(
    .DATA_W (CMD_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (front_ready),
    .data_i  (front_cmd),
    .valid_o (queue_valid),
    .pop_i   (queue_ready),
    .data_o  (queue_cmd)
  );

  ebb_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .RADIUS    (RADIUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .cmd_i       (queue_cmd),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
